>>> src/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg: shared definitions for the rectangle forest component counter
// Field widths, action codes, table indices and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

  localparam int COORD_W = 10;
  localparam int ACT_W   = 2;
  localparam int CFG_W   = 10;
  localparam int VAL_W   = 19;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(512);

  typedef logic [ACT_W-1:0] action_t;

  localparam action_t ACT_LOAD  = 2'd0;
  localparam action_t ACT_BUILD = 2'd1;
  localparam action_t ACT_QUERY = 2'd2;

  // Configuration register indices.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam int NUM_TABLES = 3;
  localparam int TBL_NODE   = 0;
  localparam int TBL_VERT   = 1;
  localparam int TBL_HORZ   = 2;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic load_edge;
    logic load_nbr;
    logic bld_init;
    logic bld_rd;
    logic bld_wr;
    logic q_rd0;
    logic q_rd1;
    logic q_diff2;
    logic q_out;
  } rfc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic bld_empty;
    logic bld_last;
    logic out_free;
  } rfc_status_t;

endpackage

`default_nettype wire

>>> src/rfc_ram.sv
// ----------------------------------------------------------------------------
// rfc_ram: table memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_ram #(
  parameter int DEPTH = 263169,
  parameter int AW    = 19,
  parameter int DW    = 19
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re_a,
  input  wire logic [AW-1:0] raddr_a,
  output      logic [DW-1:0] rdata_a,
  input  wire logic          re_b,
  input  wire logic [AW-1:0] raddr_b,
  output      logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

>>> src/rfc_datapath.sv
// ----------------------------------------------------------------------------
// rfc_datapath: tables, counters and arithmetic
// Holds the node and edge tables, the captured item, the clearing and build
// counters, the running sums of the build sweep and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_datapath #(
  parameter int MAX_WIDTH  = rfc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rfc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rfc_pkg::rfc_cmd_t             cmd,
  output      rfc_pkg::rfc_status_t          status,
  input  wire logic                          is_vertical,
  input  wire logic [rfc_pkg::COORD_W-1:0]   edge_x,
  input  wire logic [rfc_pkg::COORD_W-1:0]   edge_y,
  input  wire logic [rfc_pkg::COORD_W-1:0]   rect_xmin,
  input  wire logic [rfc_pkg::COORD_W-1:0]   rect_ymin,
  input  wire logic [rfc_pkg::COORD_W-1:0]   rect_xmax,
  input  wire logic [rfc_pkg::COORD_W-1:0]   rect_ymax,
  input  wire logic [rfc_pkg::CFG_W-1:0]     grid_width,
  input  wire logic [rfc_pkg::CFG_W-1:0]     grid_height,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [rfc_pkg::VAL_W-1:0]     components
);

  localparam int COLS  = MAX_WIDTH + 1;
  localparam int ROWS  = MAX_HEIGHT + 1;
  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(COLS);
  localparam int YW    = $clog2(ROWS);
  localparam int NT    = rfc_pkg::NUM_TABLES;
  localparam int VW    = rfc_pkg::VAL_W;
  localparam int CW    = rfc_pkg::COORD_W;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] cx,
                                              input logic [YW-1:0] cy);
    cell_addr = AW'(cx) * AW'(ROWS) + AW'(cy);
  endfunction

  // Captured item.
  logic          vert;
  logic [CW-1:0] ex_q, ey_q, xmin_q, ymin_q, xmax_q, ymax_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vert   <= is_vertical;
      ex_q   <= edge_x;
      ey_q   <= edge_y;
      xmin_q <= rect_xmin;
      ymin_q <= rect_ymin;
      xmax_q <= rect_xmax;
      ymax_q <= rect_ymax;
    end
  end

  logic edge_ok, nbr_ok, rect_ok;

  assign edge_ok = (ex_q != '0) && (ey_q != '0) &&
                   (32'(ex_q) <= MAX_WIDTH) && (32'(ey_q) <= MAX_HEIGHT);
  assign nbr_ok  = vert ? (32'(ey_q) < MAX_HEIGHT) : (32'(ex_q) < MAX_WIDTH);
  assign rect_ok = (xmin_q != '0) && (ymin_q != '0) &&
                   (32'(xmax_q) <= MAX_WIDTH) && (32'(ymax_q) <= MAX_HEIGHT) &&
                   (xmin_q <= xmax_q) && (ymin_q <= ymax_q);

  // Coordinates on the table grid; they are only used once the range checks pass.
  logic [XW-1:0] ex, qx0, qx1, qx1m;
  logic [YW-1:0] ey, qy0, qy1, qy1m;

  assign ex   = XW'(ex_q);
  assign ey   = YW'(ey_q);
  assign qx0  = XW'(xmin_q - CW'(1));
  assign qy0  = YW'(ymin_q - CW'(1));
  assign qx1  = XW'(xmax_q);
  assign qy1  = YW'(ymax_q);
  assign qx1m = XW'(xmax_q - CW'(1));
  assign qy1m = YW'(ymax_q - CW'(1));

  // Build extent, saturated to the table size.
  logic [XW-1:0] w_sat;
  logic [YW-1:0] h_sat;

  assign w_sat = (32'(grid_width) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(grid_width);
  assign h_sat = (32'(grid_height) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(grid_height);

  // Clearing pass counter.
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Table ports.
  logic [NT-1:0]         we, re;
  logic [NT-1:0][VW-1:0] wdata, ra_data, rb_data, bld_sum;
  logic [NT-1:0][AW-1:0] ra_addr, rb_addr;
  logic [AW-1:0]         w_addr;
  logic [NT-1:0][XW-1:0] rax, rbx;
  logic [NT-1:0][YW-1:0] ray, rby;
  logic [XW-1:0]         wx;
  logic [YW-1:0]         wy;

  // Build sweep state.
  logic [XW-1:0]         bx;
  logic [YW-1:0]         by;
  logic [NT-1:0][VW-1:0] left, diag;

  always_comb begin
    for (int m = 0; m < NT; m++) begin
      bld_sum[m] = ra_data[m] + rb_data[m] + left[m] - diag[m];
    end
  end

  always_comb begin
    we    = '0;
    re    = '0;
    wdata = '0;
    wx    = ex;
    wy    = ey;
    for (int m = 0; m < NT; m++) begin
      rax[m] = bx;
      ray[m] = by;
      rbx[m] = bx - XW'(1);
      rby[m] = by;
    end

    priority if (cmd.load_edge) begin
      if (edge_ok) begin
        we[rfc_pkg::TBL_NODE] = 1'b1;
        if (vert) begin
          we[rfc_pkg::TBL_VERT] = 1'b1;
        end else begin
          we[rfc_pkg::TBL_HORZ] = 1'b1;
        end
      end
      for (int m = 0; m < NT; m++) begin
        wdata[m] = VW'(1);
      end
    end else if (cmd.load_nbr) begin
      we[rfc_pkg::TBL_NODE]    = edge_ok && nbr_ok;
      wdata[rfc_pkg::TBL_NODE] = VW'(1);
      if (vert) begin
        wy = ey + YW'(1);
      end else begin
        wx = ex + XW'(1);
      end
    end else if (cmd.bld_wr) begin
      we    = '1;
      wdata = bld_sum;
      wx    = bx;
      wy    = by;
    end else begin
      we = '0;
    end

    if (cmd.bld_rd) begin
      re = '1;
    end else if (cmd.q_rd0 || cmd.q_rd1) begin
      re = {NT{rect_ok}};
      for (int m = 0; m < NT; m++) begin
        rax[m] = qx1;
        rbx[m] = qx0;
        ray[m] = cmd.q_rd0 ? qy1 : qy0;
        rby[m] = cmd.q_rd0 ? qy1 : qy0;
      end
      // Edge tables stop one short of the far side of the rectangle.
      if (cmd.q_rd0) begin
        ray[rfc_pkg::TBL_VERT] = qy1m;
        rby[rfc_pkg::TBL_VERT] = qy1m;
      end
      rax[rfc_pkg::TBL_HORZ] = qx1m;
    end
  end

  always_comb begin
    w_addr = cmd.clr_step ? clr_addr : cell_addr(wx, wy);
    for (int m = 0; m < NT; m++) begin
      ra_addr[m] = cell_addr(rax[m], ray[m]);
      rb_addr[m] = cell_addr(rbx[m], rby[m]);
    end
  end

  for (genvar g = 0; g < NT; g++) begin : g_tbl
    rfc_ram #(
      .DEPTH (CELLS),
      .AW    (AW),
      .DW    (VW)
    ) u_ram (
      .clk     (clk),
      .we      (we[g] || cmd.clr_step),
      .waddr   (w_addr),
      .wdata   (cmd.clr_step ? VW'(0) : wdata[g]),
      .re_a    (re[g]),
      .raddr_a (ra_addr[g]),
      .rdata_a (ra_data[g]),
      .re_b    (re[g]),
      .raddr_b (rb_addr[g]),
      .rdata_b (rb_data[g])
    );
  end

  // Build sweep: column by column, each column bottom to top.
  always_ff @(posedge clk) begin
    if (cmd.bld_init) begin
      bx   <= XW'(1);
      by   <= YW'(1);
      left <= '0;
      diag <= '0;
    end else if (cmd.bld_wr) begin
      if (by == h_sat) begin
        by   <= YW'(1);
        bx   <= bx + XW'(1);
        left <= '0;
        diag <= '0;
      end else begin
        by   <= by + YW'(1);
        left <= bld_sum;
        diag <= rb_data;
      end
    end
  end

  // Query corner differences.
  logic [NT-1:0][VW-1:0] d1, d2;
  logic [VW-1:0]         q_result;

  always_ff @(posedge clk) begin
    for (int m = 0; m < NT; m++) begin
      if (cmd.q_rd1) begin
        d1[m] <= ra_data[m] - rb_data[m];
      end
      if (cmd.q_diff2) begin
        d2[m] <= ra_data[m] - rb_data[m];
      end
    end
  end

  assign q_result = (d1[rfc_pkg::TBL_NODE] - d2[rfc_pkg::TBL_NODE])
                  - (d1[rfc_pkg::TBL_VERT] - d2[rfc_pkg::TBL_VERT])
                  - (d1[rfc_pkg::TBL_HORZ] - d2[rfc_pkg::TBL_HORZ]);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.q_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_out) begin
      components <= rect_ok ? q_result : '0;
    end
  end

  assign status.clr_done  = (clr_addr == AW'(CELLS - 1));
  assign status.bld_empty = (w_sat == '0) || (h_sat == '0);
  assign status.bld_last  = (bx == w_sat) && (by == h_sat);
  assign status.out_free  = !out_valid || out_ready;

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    (|we) |-> (32'(w_addr) < CELLS))
    else $error("table write outside the grid");

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    re[rfc_pkg::TBL_NODE] |-> (32'(ra_addr[rfc_pkg::TBL_NODE]) < CELLS) &&
                              (32'(rb_addr[rfc_pkg::TBL_NODE]) < CELLS))
    else $error("table read outside the grid");

  a_bld_border: assert property (@(posedge clk) disable iff (rst)
    cmd.bld_wr |-> (bx != '0) && (by != '0) && (bx <= w_sat) && (by <= h_sat))
    else $error("build sweep left the configured area");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.q_out |-> (!out_valid || out_ready))
    else $error("result loaded over one not yet taken");

  a_out_set: assert property (@(posedge clk) disable iff (rst)
    cmd.q_out |=> out_valid)
    else $error("result not presented after a query");

endmodule

`default_nettype wire

>>> src/rfc_ctrl.sv
// ----------------------------------------------------------------------------
// rfc_ctrl: sequencing controller
// Runs the clearing pass after reset, then takes one item at a time and
// steps the datapath through a load, a build sweep or a query.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire rfc_pkg::action_t      action,
  output      rfc_pkg::rfc_cmd_t     cmd,
  input  wire rfc_pkg::rfc_status_t  status
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD0,
    S_LOAD1,
    S_BINIT,
    S_BRD,
    S_BWR,
    S_Q0,
    S_Q1,
    S_Q2,
    S_QOUT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          unique case (action)
            rfc_pkg::ACT_LOAD:  state_next = S_LOAD0;
            rfc_pkg::ACT_BUILD: state_next = S_BINIT;
            rfc_pkg::ACT_QUERY: state_next = S_Q0;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD0: begin
        cmd.load_edge = 1'b1;
        state_next    = S_LOAD1;
      end
      S_LOAD1: begin
        cmd.load_nbr = 1'b1;
        state_next   = S_IDLE;
      end
      S_BINIT: begin
        cmd.bld_init = 1'b1;
        state_next   = status.bld_empty ? S_IDLE : S_BRD;
      end
      S_BRD: begin
        cmd.bld_rd = 1'b1;
        state_next = S_BWR;
      end
      S_BWR: begin
        cmd.bld_wr = 1'b1;
        state_next = status.bld_last ? S_IDLE : S_BRD;
      end
      S_Q0: begin
        cmd.q_rd0  = 1'b1;
        state_next = S_Q1;
      end
      S_Q1: begin
        cmd.q_rd1  = 1'b1;
        state_next = S_Q2;
      end
      S_Q2: begin
        cmd.q_diff2 = 1'b1;
        state_next  = S_QOUT;
      end
      S_QOUT: begin
        if (status.out_free) begin
          cmd.q_out  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/rect_forest_component_count_unit.sv
// ----------------------------------------------------------------------------
// rect_forest_component_count_unit: forest component counter over rectangles
// Loads grid edges, builds summed-area tables in place and answers
// rectangle queries with the number of forest components inside.
// ----------------------------------------------------------------------------
// After reset the block clears all (MAX_WIDTH+1)*(MAX_HEIGHT+1) entries of its
// three tables (263169 at the defaults), one entry per cycle, and holds
// s_axis_tready low meanwhile; register writes are taken throughout. It then
// handles one beat at a time. A load writes in two steps, set by the single write
// port of the node table (two nodes are marked). A build sweeps the
// saturated grid size w by h: every cell is read
// in one cycle and written back in the next. A query makes four
// corner reads per table spread over the two read ports, and its result sits
// in an output register, so the next beat is taken while it waits on
// m_axis_tready; a later query waits to deliver until that result is taken.
`default_nettype none

module rect_forest_component_count_unit #(
  parameter int MAX_WIDTH  = rfc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rfc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [0] is_vertical, [10:1] edge_x, [20:11] edge_y, [30:21] rect_xmin,
  // [40:31] rect_ymin, [50:41] rect_xmax, [60:51] rect_ymax, [63:61] zero
  input  wire logic [63:0] s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]  s_axis_tuser,
  // Result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [18:0] components, [23:19] zero
  output      logic [23:0] m_axis_tdata,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int CW = rfc_pkg::COORD_W;
  localparam int FW = rfc_pkg::CFG_W;
  localparam int VW = rfc_pkg::VAL_W;

  // Configuration registers.
  logic [FW-1:0] grid_width, grid_height;
  logic          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= rfc_pkg::GRID_RESET;
      grid_height <= rfc_pkg::GRID_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        rfc_pkg::REG_GRID_WIDTH:  grid_width  <= pwdata[FW-1:0];
        rfc_pkg::REG_GRID_HEIGHT: grid_height <= pwdata[FW-1:0];
        default:                  grid_width  <= grid_width;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rfc_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width);
      rfc_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height);
      default:                  prdata = '0;
    endcase
  end

  // Beat fields.
  logic          is_vertical;
  logic [CW-1:0] edge_x, edge_y, rect_xmin, rect_ymin, rect_xmax, rect_ymax;

  assign is_vertical = s_axis_tdata[0];
  assign edge_x      = s_axis_tdata[10:1];
  assign edge_y      = s_axis_tdata[20:11];
  assign rect_xmin   = s_axis_tdata[30:21];
  assign rect_ymin   = s_axis_tdata[40:31];
  assign rect_xmax   = s_axis_tdata[50:41];
  assign rect_ymax   = s_axis_tdata[60:51];

  rfc_pkg::rfc_cmd_t    cmd;
  rfc_pkg::rfc_status_t status;
  logic [VW-1:0]        components;

  rfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .action   (s_axis_tuser),
    .cmd      (cmd),
    .status   (status)
  );

  rfc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .is_vertical (is_vertical),
    .edge_x      (edge_x),
    .edge_y      (edge_y),
    .rect_xmin   (rect_xmin),
    .rect_ymin   (rect_ymin),
    .rect_xmax   (rect_xmax),
    .rect_ymax   (rect_ymax),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .components  (components)
  );

  assign m_axis_tdata = 24'(components);

endmodule

`default_nettype wire

>>> sim/tb_rect_forest_component_count_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_forest_component_count_unit: self-checking bench for the counter
// Loads grid edges, triggers table builds and sends rectangle queries on the
// input stream, sets the grid size over the register port between phases,
// and checks every returned count against a typed-in count or a behavioural
// copy of the three summed-area tables kept inside the bench.
// ----------------------------------------------------------------------------
module tb_rect_forest_component_count_unit;

  localparam int COORD_W      = rfc_pkg::COORD_W;
  localparam int VAL_W        = rfc_pkg::VAL_W;
  localparam int CFG_W        = rfc_pkg::CFG_W;
  localparam int MAXW         = rfc_pkg::DEF_MAX_WIDTH;
  localparam int MAXH         = rfc_pkg::DEF_MAX_HEIGHT;
  localparam int CELLS        = (MAXW + 1) * (MAXH + 1);
  localparam int TARGET_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_LIMIT  = 200_000;
  localparam int MAX_PRINTED  = 40;
  localparam rfc_pkg::action_t ACT_UNUSED = 2'd3;

  typedef enum bit {ROW_BEAT, ROW_GRID} row_kind_t;
  typedef enum bit [1:0] {SINK_OPEN, SINK_RANDOM, SINK_BURSTY} sink_mode_t;
  typedef enum bit [1:0] {BAD_ZERO, BAD_HIGH, BAD_X_ORDER, BAD_Y_ORDER} bad_rect_t;

  typedef struct packed {
    rfc_pkg::action_t   act;
    bit                 vert;
    bit [COORD_W-1:0]   ex;
    bit [COORD_W-1:0]   ey;
    bit [COORD_W-1:0]   xmin;
    bit [COORD_W-1:0]   ymin;
    bit [COORD_W-1:0]   xmax;
    bit [COORD_W-1:0]   ymax;
  } beat_t;

  // On grid rows ex and ey carry the width and height to be written.
  typedef struct packed {
    row_kind_t          kind;
    rfc_pkg::action_t   act;
    bit                 vert;
    bit [COORD_W-1:0]   ex;
    bit [COORD_W-1:0]   ey;
    bit [COORD_W-1:0]   xmin;
    bit [COORD_W-1:0]   ymin;
    bit [COORD_W-1:0]   xmax;
    bit [COORD_W-1:0]   ymax;
    bit                 typed;
    bit [VAL_W-1:0]     count;
  } row_t;

  row_t dir_table [29] = '{
    // Tables are all clear after reset.
    '{ROW_BEAT, rfc_pkg::ACT_QUERY, 1'b0,   0,    0,   1,  1,  512,  512, 1'b1, 0},
    // Rectangles that are out of range or inside out give zero.
    '{ROW_BEAT, rfc_pkg::ACT_QUERY, 1'b0,   0,    0,   0,  5,    9,    9, 1'b1, 0},
    '{ROW_BEAT, rfc_pkg::ACT_QUERY, 1'b0,   0,    0,   1,  1,    9,  513, 1'b1, 0},
    '{ROW_BEAT, rfc_pkg::ACT_QUERY, 1'b0,   0,    0,   7,  1,    3,    9, 1'b1, 0},
    '{ROW_BEAT, rfc_pkg::ACT_QUERY, 1'b0,   0,    0,   1,  9, 1023,    2, 1'b1, 0},
    '{ROW_BEAT, ACT_UNUSED,         1'b1,   5,    5,   1,  1,    2,    2, 1'b0, 0},
    // Far endpoints off the grid, then edges that lie off the grid.
    '{ROW_BEAT, rfc_pkg::ACT_LOAD,  1'b1, 512,  512,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_LOAD,  1'b0, 512,  511,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_LOAD,  1'b1,   0,    4,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_LOAD,  1'b0,   3, 1023,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_LOAD,  1'b1, 513,    1,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_LOAD,  1'b1,   1,    1,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_LOAD,  1'b0,   1,    1,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_LOAD,  1'b0,   2,    2,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_QUERY, 1'b0,   0,    0,   1,  1,    2,    2, 1'b0, 0},
    // Oversized width saturates to the full grid.
    '{ROW_GRID, rfc_pkg::ACT_LOAD,  1'b0, 1023,   1,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_BUILD, 1'b0,   0,    0,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_QUERY, 1'b0,   0,    0,   1,  1,  512,    1, 1'b0, 0},
    '{ROW_GRID, rfc_pkg::ACT_LOAD,  1'b0,   1, 1023,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_BUILD, 1'b0,   0,    0,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_QUERY, 1'b0,   0,    0,   1,  1,  512,  512, 1'b0, 0},
    // A zero size builds nothing.
    '{ROW_GRID, rfc_pkg::ACT_LOAD,  1'b0,   0,    0,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_BUILD, 1'b0,   0,    0,   0,  0,    0,    0, 1'b0, 0},
    // A load after a build overwrites a summed entry, then two builds in a row.
    '{ROW_BEAT, rfc_pkg::ACT_LOAD,  1'b1,   2,    1,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_GRID, rfc_pkg::ACT_LOAD,  1'b0,   3,    3,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_BUILD, 1'b0,   0,    0,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_BUILD, 1'b0,   0,    0,   0,  0,    0,    0, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_QUERY, 1'b0,   0,    0,   1,  1,    3,    3, 1'b0, 0},
    '{ROW_BEAT, rfc_pkg::ACT_QUERY, 1'b0,   0,    0, 512, 511, 512,  512, 1'b0, 0}
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // Bench copy of the tables and the grid registers.
  bit [VAL_W-1:0] sat_tab [rfc_pkg::NUM_TABLES][CELLS];
  bit [CFG_W-1:0] grid_w_reg = rfc_pkg::GRID_RESET;
  bit [CFG_W-1:0] grid_h_reg = rfc_pkg::GRID_RESET;
  int unsigned    quiet_tail = 0;

  bit [VAL_W-1:0] expected_counts [$];
  int             err_count   = 0;
  int             items_sent  = 0;
  int             burst_left  = 0;
  bit             no_gaps     = 1'b0;
  longint         cycle_count = 0;

  rect_forest_component_count_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int cell_at(int x, int y);
    return x * (MAXH + 1) + y;
  endfunction

  function automatic bit [VAL_W-1:0] box_sum(int t, int x0, int y0, int x1, int y1);
    return sat_tab[t][cell_at(x1, y1)] - sat_tab[t][cell_at(x0, y1)]
         - sat_tab[t][cell_at(x1, y0)] + sat_tab[t][cell_at(x0, y0)];
  endfunction

  // Applies one accepted beat to the bench tables and returns the count a
  // query should produce. quiet_tail tracks how long the block may stay busy
  // on beats that return nothing.
  task automatic forest_step(input beat_t b, output bit has_count,
                             output bit [VAL_W-1:0] count);
    int x;
    int y;
    int w;
    int h;
    has_count = 1'b0;
    count     = '0;
    case (b.act)
      rfc_pkg::ACT_LOAD: begin
        x = b.ex;
        y = b.ey;
        quiet_tail += 3;
        if (x >= 1 && x <= MAXW && y >= 1 && y <= MAXH) begin
          sat_tab[rfc_pkg::TBL_NODE][cell_at(x, y)] = 1;
          if (b.vert) begin
            if (y + 1 <= MAXH) sat_tab[rfc_pkg::TBL_NODE][cell_at(x, y + 1)] = 1;
            sat_tab[rfc_pkg::TBL_VERT][cell_at(x, y)] = 1;
          end else begin
            if (x + 1 <= MAXW) sat_tab[rfc_pkg::TBL_NODE][cell_at(x + 1, y)] = 1;
            sat_tab[rfc_pkg::TBL_HORZ][cell_at(x, y)] = 1;
          end
        end
      end
      rfc_pkg::ACT_BUILD: begin
        w = (grid_w_reg > MAXW) ? MAXW : grid_w_reg;
        h = (grid_h_reg > MAXH) ? MAXH : grid_h_reg;
        quiet_tail += 2 + 2 * w * h;
        for (int t = 0; t < rfc_pkg::NUM_TABLES; t++)
          for (int i = 1; i <= w; i++)
            for (int j = 1; j <= h; j++)
              sat_tab[t][cell_at(i, j)] = sat_tab[t][cell_at(i, j)]
                  + sat_tab[t][cell_at(i - 1, j)] + sat_tab[t][cell_at(i, j - 1)]
                  - sat_tab[t][cell_at(i - 1, j - 1)];
      end
      rfc_pkg::ACT_QUERY: begin
        quiet_tail = 0;
        has_count  = 1'b1;
        if (b.xmin >= 1 && b.ymin >= 1 && b.xmax <= MAXW && b.ymax <= MAXH &&
            b.xmin <= b.xmax && b.ymin <= b.ymax) begin
          count = box_sum(rfc_pkg::TBL_NODE, b.xmin - 1, b.ymin - 1, b.xmax, b.ymax)
                - box_sum(rfc_pkg::TBL_VERT, b.xmin - 1, b.ymin - 1, b.xmax, b.ymax - 1)
                - box_sum(rfc_pkg::TBL_HORZ, b.xmin - 1, b.ymin - 1, b.xmax - 1, b.ymax);
        end
      end
      default: begin
        quiet_tail += 1;
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic beat_t noise_beat(rfc_pkg::action_t a);
    beat_t b;
    b.act  = a;
    b.vert = 1'($urandom);
    b.ex   = COORD_W'($urandom);
    b.ey   = COORD_W'($urandom);
    b.xmin = COORD_W'($urandom);
    b.ymin = COORD_W'($urandom);
    b.xmax = COORD_W'($urandom);
    b.ymax = COORD_W'($urandom);
    return b;
  endfunction

  // Mostly inside the built region, now and then anywhere or off the grid.
  function automatic bit [COORD_W-1:0] pick_coord(int span);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)
      return ($urandom_range(0, 1) == 0) ? '0 : COORD_W'($urandom_range(MAXW + 1, 1023));
    if (r < 3) return COORD_W'($urandom_range(1, MAXW));
    return COORD_W'($urandom_range(1, span));
  endfunction

  function automatic beat_t make_load(int xs, int ys);
    beat_t b;
    b    = noise_beat(rfc_pkg::ACT_LOAD);
    b.ex = pick_coord(xs);
    b.ey = pick_coord(ys);
    return b;
  endfunction

  function automatic beat_t make_query(int xs, int ys, bit bad);
    beat_t            b;
    bit [COORD_W-1:0] a;
    bit [COORD_W-1:0] c;
    b = noise_beat(rfc_pkg::ACT_QUERY);
    a = pick_coord(xs);
    c = pick_coord(xs);
    b.xmin = (a < c) ? a : c;
    b.xmax = (a < c) ? c : a;
    a = pick_coord(ys);
    c = pick_coord(ys);
    b.ymin = (a < c) ? a : c;
    b.ymax = (a < c) ? c : a;
    if (bad) begin
      case (bad_rect_t'($urandom_range(0, 3)))
        BAD_ZERO: begin
          if ($urandom_range(0, 1)) b.xmin = '0;
          else b.ymin = '0;
        end
        BAD_HIGH: begin
          if ($urandom_range(0, 1)) b.xmax = COORD_W'($urandom_range(MAXW + 1, 1023));
          else b.ymax = COORD_W'($urandom_range(MAXH + 1, 1023));
        end
        BAD_X_ORDER: begin
          b.xmax = COORD_W'($urandom_range(1, xs));
          b.xmin = b.xmax + COORD_W'($urandom_range(1, 8));
        end
        default: begin
          b.ymax = COORD_W'($urandom_range(1, ys));
          b.ymin = b.ymax + COORD_W'($urandom_range(1, 8));
        end
      endcase
    end
    return b;
  endfunction

  // Entered and left at a falling edge. The sender works in bursts with
  // random gaps between them unless no_gaps is set for the phase.
  task automatic send_beat(input beat_t b, input bit typed, input bit [VAL_W-1:0] typed_count);
    int             gap;
    bit             has_count;
    bit [VAL_W-1:0] count;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) begin
          @(posedge clk);
          @(negedge clk);
        end
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, b.ymax, b.xmax, b.ymin, b.xmin, b.ey, b.ex, b.vert};
    s_axis_tuser  <= b.act;
    do @(posedge clk); while (!s_axis_tready);
    forest_step(b, has_count, count);
    if (has_count) expected_counts = {expected_counts, (typed ? typed_count : count)};
    if (b.act != ACT_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Lets the block run dry before the grid registers are touched.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (quiet_tail + 8) @(posedge clk);
    quiet_tail = 0;
    @(negedge clk);
  endtask

  // One register access: setup cycle, then access until pready. A read is
  // checked against the bench copy of the register.
  task automatic apb_access(input logic idx, input bit wr, input bit [31:0] data);
    bit [CFG_W-1:0] held;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      if (idx == rfc_pkg::REG_GRID_WIDTH) grid_w_reg = data[CFG_W-1:0];
      else grid_h_reg = data[CFG_W-1:0];
    end else begin
      held = (idx == rfc_pkg::REG_GRID_WIDTH) ? grid_w_reg : grid_h_reg;
      if (prdata !== 32'(held))
        report_mismatch($sformatf("register %0d read %0h, expected %0h", idx, prdata, held));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    @(negedge clk);
  endtask

  // Upper bits of the write data are sometimes set; the registers keep ten.
  task automatic set_grid(input bit [CFG_W-1:0] w, input bit [CFG_W-1:0] h);
    bit [31:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_FC00) : 32'd0;
    apb_access(rfc_pkg::REG_GRID_WIDTH, 1'b1, junk | 32'(w));
    apb_access(rfc_pkg::REG_GRID_HEIGHT, 1'b1, junk | 32'(h));
    apb_access(rfc_pkg::REG_GRID_WIDTH, 1'b0, 32'd0);
    apb_access(rfc_pkg::REG_GRID_HEIGHT, 1'b0, 32'd0);
  endtask

  always @(posedge clk) begin : check_results
    bit [VAL_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("result beat with no query pending, components %0d",
                                  m_axis_tdata[VAL_W-1:0]));
      end else begin
        want = expected_counts.pop_front();
        if (m_axis_tdata[VAL_W-1:0] !== want)
          report_mismatch($sformatf("components %0d, expected %0d",
                                    m_axis_tdata[VAL_W-1:0], want));
      end
    end
  end

  // The receiver switches between always ready, random stalls and long
  // on/off stretches.
  initial begin : result_sink
    sink_mode_t mode;
    int         span;
    int         hold;
    bit         open;
    hold = 0;
    open = 1'b1;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 2));
      span = $urandom_range(100, 1500);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          SINK_OPEN: m_axis_tready <= 1'b1;
          SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 9) < 7);
          default: begin
            if (hold == 0) begin
              open = !open;
              hold = open ? $urandom_range(1, 12) : $urandom_range(1, 25);
            end
            hold--;
            m_axis_tready <= open;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_rect_forest_component_count_unit: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    beat_t b;
    int    w;
    int    h;
    int    xs;
    int    ys;
    int    r;
    int    drain;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register reset values, read while the clearing pass runs.
    apb_access(rfc_pkg::REG_GRID_WIDTH, 1'b0, 32'd0);
    apb_access(rfc_pkg::REG_GRID_HEIGHT, 1'b0, 32'd0);

    for (int i = 0; i < $size(dir_table); i++) begin
      if (dir_table[i].kind == ROW_GRID) begin
        wait_idle();
        set_grid(dir_table[i].ex, dir_table[i].ey);
      end else begin
        b.act  = dir_table[i].act;
        b.vert = dir_table[i].vert;
        b.ex   = dir_table[i].ex;
        b.ey   = dir_table[i].ey;
        b.xmin = dir_table[i].xmin;
        b.ymin = dir_table[i].ymin;
        b.xmax = dir_table[i].xmax;
        b.ymax = dir_table[i].ymax;
        send_beat(b, dir_table[i].typed, dir_table[i].count);
      end
    end

    // Random phases: a grid size, a run of loads, one or two builds, then a mix of
    // queries, late loads and rebuilds, closed by a query.
    while (items_sent < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin w = 0; h = $urandom_range(0, 24); end
        1: begin w = $urandom_range(0, 24); h = 0; end
        2: begin w = $urandom_range(MAXW, 1023); h = $urandom_range(1, 2); end
        3: begin w = $urandom_range(1, 2); h = $urandom_range(MAXH, 1023); end
        4: begin w = 1; h = 1; end
        default: begin w = $urandom_range(2, 24); h = $urandom_range(2, 24); end
      endcase
      wait_idle();
      set_grid(CFG_W'(w), CFG_W'(h));
      no_gaps = ($urandom_range(0, 3) == 0);
      xs = (w > MAXW) ? MAXW : w;
      ys = (h > MAXH) ? MAXH : h;
      if (xs == 0) xs = 8;
      if (ys == 0) ys = 8;
      xs = (xs + 1 > MAXW) ? MAXW : xs + 1;
      ys = (ys + 1 > MAXH) ? MAXH : ys + 1;

      repeat ($urandom_range(4, 30)) begin
        if ($urandom_range(0, 14) == 0) b = noise_beat(ACT_UNUSED);
        else b = make_load(xs, ys);
        send_beat(b, 1'b0, '0);
      end
      repeat ($urandom_range(1, 2)) send_beat(noise_beat(rfc_pkg::ACT_BUILD), 1'b0, '0);
      repeat ($urandom_range(10, 40)) begin
        r = $urandom_range(0, 99);
        if (r < 60) b = make_query(xs, ys, 1'b0);
        else if (r < 70) b = make_query(xs, ys, 1'b1);
        else if (r < 85) b = make_load(xs, ys);
        else if (r < 90) b = noise_beat(rfc_pkg::ACT_BUILD);
        else b = noise_beat(ACT_UNUSED);
        send_beat(b, 1'b0, '0);
      end
      send_beat(make_query(xs, ys, 1'b0), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    drain = 0;
    while (expected_counts.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (quiet_tail + 20) @(posedge clk);
    if (expected_counts.size() != 0)
      report_mismatch($sformatf("%0d query results never arrived", expected_counts.size()));

    if (err_count == 0) begin
      $display("tb_rect_forest_component_count_unit: done, clean");
    end else begin
      $display("tb_rect_forest_component_count_unit: done, errors");
    end
    $finish;
  end

endmodule
